/* hdl/xzsb_pkg.sv */
// Shared types, constants and CRC-32 helper for the XZ stream boundary scanner.
// Used by every module under hdl/; depends on nothing.

package xzsb_pkg;

    // Field widths of the result item
    localparam int DATA_BYTE_W      = 8;
    localparam int STREAM_BYTES_W   = 32;
    localparam int STREAMS_FOUND_W  = 16;
    localparam int TOTAL_BYTES_W    = 32;
    localparam int M_TDATA_USED_W   = STREAM_BYTES_W + STREAMS_FOUND_W + TOTAL_BYTES_W + 1;
    localparam int M_TDATA_W        = ((M_TDATA_USED_W + 7) / 8) * 8;

    // Defaults for the top-level parameters
    localparam int LENGTH_BITS_DEF  = 32;
    localparam int COUNT_BITS_DEF   = 16;

    // Header and footer geometry
    localparam int WIN_LEN          = 12;
    localparam int FOOT_MIN         = 2 * WIN_LEN;
    localparam int HEAD_MAGIC_LEN   = 6;

    // Result queue depth (holds two results per item plus slack)
    localparam int FIFO_DEPTH       = 4;

    // Result kinds
    localparam logic KIND_STREAM    = 1'b0;
    localparam logic KIND_SUMMARY   = 1'b1;

    typedef logic [7:0] byte_t;
    typedef byte_t [WIN_LEN-1:0] window_t;  // [0] oldest, [WIN_LEN-1] newest

    localparam byte_t [HEAD_MAGIC_LEN-1:0] HEAD_MAGIC =
        {8'h00, 8'h5A, 8'h58, 8'h7A, 8'h37, 8'hFD};
    localparam byte_t FOOT_MAGIC_0  = 8'h59;
    localparam byte_t FOOT_MAGIC_1  = 8'h5A;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    typedef struct packed {
        logic                         kind;
        logic [STREAM_BYTES_W-1:0]    stream_bytes;
        logic [STREAMS_FOUND_W-1:0]   streams_found;
        logic [TOTAL_BYTES_W-1:0]     total_bytes;
        logic                         found_any;
        logic                         last_result;
    } result_t;

    // Up to two results written by one item; b is used only when a is
    typedef struct packed {
        logic    a_valid;
        result_t a;
        logic    b_valid;
        result_t b;
    } push_t;

    // Advance a reflected CRC-32 by one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in, input byte_t b);
        logic [31:0] c;
        c = crc_in ^ {24'h000000, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* hdl/xzsb_match.sv */
// Header and footer checks on a 12-byte window: magic bytes and stored CRC-32.
// Depends on xzsb_pkg.

module xzsb_match
    import xzsb_pkg::*;
(
    input  window_t win,
    output logic    header_ok,
    output logic    footer_ok
);

    logic [31:0] head_crc;
    logic [31:0] foot_crc;
    logic        head_magic_ok;

    // CRC-32 of the two stream flag bytes
    always_comb begin
        head_crc = CRC_INIT;
        for (int i = 6; i < 8; i++) begin
            head_crc = crc32_byte(head_crc, win[i]);
        end
        head_crc = head_crc ^ CRC_INIT;
    end

    // CRC-32 of footer bytes 4..9
    always_comb begin
        foot_crc = CRC_INIT;
        for (int i = 4; i < 10; i++) begin
            foot_crc = crc32_byte(foot_crc, win[i]);
        end
        foot_crc = foot_crc ^ CRC_INIT;
    end

    assign head_magic_ok = (win[HEAD_MAGIC_LEN-1:0] == HEAD_MAGIC);

    assign header_ok = head_magic_ok && (head_crc == {win[11], win[10], win[9], win[8]});

    assign footer_ok = (win[10] == FOOT_MAGIC_0) && (win[11] == FOOT_MAGIC_1) &&
                       (foot_crc == {win[3], win[2], win[1], win[0]});

endmodule

/* hdl/xzsb_scan.sv */
// Scan state machine: byte window, stream length, tallies and result build.
// Depends on xzsb_pkg and xzsb_match.

module xzsb_scan
    import xzsb_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   item_valid,
    input  logic [DATA_BYTE_W-1:0] data_byte,
    input  logic                   is_last,
    output push_t                  push
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SCAN,
        PH_STOP
    } phase_t;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0]  CNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] HEAD_END = LENGTH_BITS'(WIN_LEN);
    localparam logic [LENGTH_BITS-1:0] FOOT_END = LENGTH_BITS'(FOOT_MIN);

    phase_t                 phase_reg, phase_next;
    window_t                window_reg, window_next;
    logic [LENGTH_BITS-1:0] cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0]  tally_reg, tally_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;

    window_t                win_shift;
    logic                   header_ok;
    logic                   footer_ok;
    logic [LENGTH_BITS-1:0] cnt_inc;
    logic [COUNT_BITS-1:0]  tally_inc;
    logic [LENGTH_BITS:0]   len_sum;
    logic [LENGTH_BITS-1:0] len_sat;
    logic                   stream_done;
    logic [COUNT_BITS-1:0]  tally_after;
    logic [LENGTH_BITS-1:0] len_after;

    logic [COUNT_BITS+STREAMS_FOUND_W-1:0] tally_ext;
    logic [LENGTH_BITS+TOTAL_BYTES_W-1:0]  len_ext;
    logic [LENGTH_BITS+STREAM_BYTES_W-1:0] size_ext;
    result_t                               stream_res;
    result_t                               summary_res;

    // Shift the new byte into the newest slot
    assign win_shift = {data_byte, window_reg[WIN_LEN-1:1]};

    xzsb_match u_match (
        .win       (win_shift),
        .header_ok (header_ok),
        .footer_ok (footer_ok)
    );

    // Saturating counters
    assign cnt_inc   = (cnt_reg == LEN_MAX) ? cnt_reg : cnt_reg + 1'b1;
    assign tally_inc = (tally_reg == CNT_MAX) ? tally_reg : tally_reg + 1'b1;
    assign len_sum   = {1'b0, len_reg} + {1'b0, cnt_inc};
    assign len_sat   = len_sum[LENGTH_BITS] ? LEN_MAX : len_sum[LENGTH_BITS-1:0];

    assign stream_done = item_valid && (phase_reg == PH_SCAN) &&
                         (cnt_inc >= FOOT_END) && footer_ok;

    assign tally_after = stream_done ? tally_inc : tally_reg;
    assign len_after   = stream_done ? len_sat : len_reg;

    // Fit tallies and size to the result field widths
    assign tally_ext = {{STREAMS_FOUND_W{1'b0}}, tally_after};
    assign len_ext   = {{TOTAL_BYTES_W{1'b0}}, len_after};
    assign size_ext  = {{STREAM_BYTES_W{1'b0}}, cnt_inc};

    always_comb begin
        stream_res.kind          = KIND_STREAM;
        stream_res.stream_bytes  = size_ext[STREAM_BYTES_W-1:0];
        stream_res.streams_found = tally_ext[STREAMS_FOUND_W-1:0];
        stream_res.total_bytes   = len_ext[TOTAL_BYTES_W-1:0];
        stream_res.found_any     = (tally_after != '0);
        stream_res.last_result   = !is_last;

        summary_res              = stream_res;
        summary_res.kind         = KIND_SUMMARY;
        summary_res.stream_bytes = '0;
        summary_res.last_result  = 1'b1;
    end

    // Next state and result pushes
    always_comb begin
        phase_next  = phase_reg;
        window_next = window_reg;
        cnt_next    = cnt_reg;
        tally_next  = tally_reg;
        len_next    = len_reg;
        push        = '0;

        if (item_valid) begin
            if (phase_reg != PH_STOP) begin
                window_next = win_shift;
                cnt_next    = cnt_inc;
                if (phase_reg == PH_HEADER) begin
                    if (cnt_inc >= HEAD_END) begin
                        phase_next = header_ok ? PH_SCAN : PH_STOP;
                    end
                end else if (stream_done) begin
                    tally_next   = tally_inc;
                    len_next     = len_sat;
                    push.a_valid = 1'b1;
                    push.a       = stream_res;
                    phase_next   = PH_HEADER;
                    cnt_next     = '0;
                end
            end

            // Report the summary and start over for the next blob
            if (is_last) begin
                if (stream_done) begin
                    push.b_valid = 1'b1;
                    push.b       = summary_res;
                end else begin
                    push.a_valid = 1'b1;
                    push.a       = summary_res;
                end
                phase_next = PH_HEADER;
                cnt_next   = '0;
                tally_next = '0;
                len_next   = '0;
            end
        end
    end

    // Hold state
    always_ff @(posedge aclk) begin
        window_reg <= window_next;
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            cnt_reg   <= '0;
            tally_reg <= '0;
            len_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            tally_reg <= tally_next;
            len_reg   <= len_next;
        end
    end

endmodule

/* hdl/xzsb_fifo.sv */
// Result queue: takes up to two result items per cycle, hands out one.
// Depends on xzsb_pkg.

module xzsb_fifo
    import xzsb_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  push_t   push,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t out_data,
    output logic    can_take
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(FIFO_DEPTH - 2);

    result_t            mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wr_ptr_b;
    logic               pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign can_take  = (count_reg <= ROOM_LIMIT);
    assign wr_ptr_b  = wr_ptr_reg + 1'b1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.a_valid) + PTR_W'(push.b_valid);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.a_valid) + CNT_W'(push.b_valid)
                      - CNT_W'(pop);
    end

    // Store pushed items
    always_ff @(posedge aclk) begin
        if (push.a_valid) begin
            mem_reg[wr_ptr_reg] <= push.a;
        end
        if (push.b_valid) begin
            mem_reg[wr_ptr_b] <= push.b;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hdl/xz_stream_boundary_scanner.sv */
// XZ stream boundary scanner, top level: input register, scan logic, result queue.
// A result item passes the input register and then the result queue before it is offered.
// Throughput: one byte per cycle, but input stalls while the four-entry queue holds 3 or 4;
// a byte ending a stream and the blob yields two result items, out one per cycle on m_tready.
// Reset: synchronous, active-low aresetn clears scan phase and byte count, tallies and queue.
// Depends on xzsb_pkg, xzsb_scan, xzsb_match and xzsb_fifo.

module xz_stream_boundary_scanner
    import xzsb_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,   // is_last
    // Result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] stream_bytes, [47:32] streams_found,
                                            // [79:48] total_bytes, [80] found_any, rest 0
    output logic                 m_tuser,   // [0] result_kind
    output logic                 m_tlast    // last_result
);

    localparam int PAD_W = M_TDATA_W - M_TDATA_USED_W;

    logic                   in_valid_reg;
    logic [DATA_BYTE_W-1:0] in_byte_reg;
    logic                   in_last_reg;
    logic                   fire;
    logic                   can_take;
    push_t                  push;
    result_t                out_res;

    assign fire     = in_valid_reg && can_take;
    assign s_tready = !in_valid_reg || fire;

    // Input register
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    xzsb_scan #(
        .LENGTH_BITS (LENGTH_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (fire),
        .data_byte  (in_byte_reg),
        .is_last    (in_last_reg),
        .push       (push)
    );

    xzsb_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .can_take  (can_take)
    );

    // Pack the result item
    assign m_tdata = {{PAD_W{1'b0}}, out_res.found_any, out_res.total_bytes,
                      out_res.streams_found, out_res.stream_bytes};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last_result;

endmodule
